@@ rtl/core/occupancy_grid_scan_hit_update_core_assert.svh @@
// Assertion macros for the occupancy grid core.
// OGSH_ASSERT_IMP checks cons in the same cycle as ante.
// OGSH_ASSERT_NXT checks cons in the cycle after ante.
`ifndef OCCUPANCY_GRID_SCAN_HIT_UPDATE_CORE_ASSERT_SVH
`define OCCUPANCY_GRID_SCAN_HIT_UPDATE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define OGSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define OGSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OGSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define OGSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/ogsh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogsh_pkg
// Shared types, register indexes and constants of the occupancy grid core.
// ----------------------------------------------------------------------------
package ogsh_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_M  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ANGLE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE    = 3'd7;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // linear cell index before the store limit check: 11 x 11 bits plus 11
    localparam int unsigned IDX_W = 22;

    localparam logic [30:0] MIN_RANGE   = 31'd656;
    localparam logic [7:0]  CELL_RESET  = 8'd127;
    localparam logic [7:0]  HIT_STEP    = 8'd10;
    localparam logic [7:0]  HIT_LIMIT   = 8'd200;
    localparam logic [7:0]  HIT_SAT     = 8'd250;

    localparam int unsigned CORDIC_W     = 34;
    localparam logic [4:0]  CORDIC_LAST  = 5'd23;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [16:0] QUARTER_TURN = 17'sd16384;
    localparam logic signed [16:0] HALF_TURN    = 17'sd32768;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] pose_heading;
        logic [11:0]        beam_index;
        logic [30:0]        beam_range;
        logic signed [11:0] cell_x;
        logic signed [11:0] cell_y;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  cell_value;
        logic        cell_valid;
        logic [15:0] cell_address;
    } t_out_item;

    typedef struct packed {
        logic [10:0]        grid_width;
        logic [10:0]        grid_height;
        logic [31:0]        cells_per_meter;
        logic signed [31:0] grid_origin_x;
        logic signed [31:0] grid_origin_y;
        logic signed [15:0] first_beam_angle;
        logic signed [15:0] beam_angle_step;
        logic [30:0]        max_valid_range;
    } t_cfg;

    typedef struct packed {
        logic             op;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [3:0] {
        FR_IDLE, FR_ANGLE, FR_ROT, FR_PROJ, FR_SUM, FR_SCALE, FR_CELL, FR_BOUND, FR_ADDR
    } t_front_state;

    typedef enum logic [1:0] {
        BK_CLEAR, BK_IDLE, BK_RMW
    } t_back_state;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [CORDIC_W-1:0] atan_step(input logic [4:0] i);
        logic signed [CORDIC_W-1:0] v;
        case (i)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/ogsh_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogsh_front
// Accepts items, runs the angle, CORDIC and cell projection sequencer and
// queues one job per item for the cell store.
// ----------------------------------------------------------------------------
module ogsh_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ogsh_pkg::t_cfg      i_cfg,
    input  logic                i_enable,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ogsh_pkg::t_in_item  i_in_item,
    output logic                o_push,
    output ogsh_pkg::t_job      o_job,
    input  ogsh_pkg::t_q_status i_q_status
);

    localparam int unsigned CW    = ogsh_pkg::CORDIC_W;
    localparam int unsigned OFF_W = 38;
    localparam int unsigned D_W   = 40;
    localparam int unsigned P_W   = D_W + 16;
    localparam int unsigned G_W   = P_W - 16 + 2;

    ogsh_pkg::t_front_state r_state, n_state;

    logic                    r_op;
    logic [15:0]             r_ang;
    logic [30:0]             r_range;
    logic signed [31:0]      r_pose_x, r_pose_y;
    logic signed [CW-1:0]    r_x, r_y, r_z;
    logic                    r_neg;
    logic [4:0]              r_step;
    logic signed [OFF_W-1:0] r_offx, r_offy;
    logic                    r_sx, r_sy;
    logic [D_W-1:0]          r_mx, r_my;
    logic [P_W-1:0]          r_mxh, r_mxl, r_myh, r_myl;
    logic signed [G_W-1:0]   r_gx, r_gy;
    logic                    r_inb;
    logic [10:0]             r_cx, r_cy;

    logic                    w_accept;
    logic                    w_range_ok;
    logic signed [16:0]      w_a, w_fold;
    logic                    w_fold_neg;
    logic signed [CW-1:0]    w_xs, w_ys, w_atan, w_c, w_s;
    logic signed [67:0]      w_px, w_py;
    logic signed [D_W-1:0]   w_dx, w_dy;
    logic [P_W:0]            w_sumx, w_sumy;
    logic signed [G_W-1:0]   w_qx, w_qy;
    logic [ogsh_pkg::IDX_W-1:0] w_idx;

    assign o_in_ready = (r_state == ogsh_pkg::FR_IDLE) && i_enable;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_range_ok = (i_in_item.beam_range >= ogsh_pkg::MIN_RANGE)
                     && (i_in_item.beam_range <= i_cfg.max_valid_range);

    // fold into [-quarter, +quarter] turn, a half turn flips the result sign
    always_comb begin
        w_a = {r_ang[15], r_ang};
        if (w_a > ogsh_pkg::QUARTER_TURN) begin
            w_fold     = w_a - ogsh_pkg::HALF_TURN;
            w_fold_neg = 1'b1;
        end else if (w_a < -ogsh_pkg::QUARTER_TURN) begin
            w_fold     = w_a + ogsh_pkg::HALF_TURN;
            w_fold_neg = 1'b1;
        end else begin
            w_fold     = w_a;
            w_fold_neg = 1'b0;
        end
    end

    assign w_xs   = r_x >>> r_step;
    assign w_ys   = r_y >>> r_step;
    assign w_atan = ogsh_pkg::atan_step(r_step);
    assign w_c    = r_neg ? -r_x : r_x;
    assign w_s    = r_neg ? -r_y : r_y;
    assign w_px   = $signed({3'b000, r_range}) * w_c;
    assign w_py   = $signed({3'b000, r_range}) * w_s;

    assign w_dx = D_W'(r_pose_x) + D_W'(r_offx) - D_W'(i_cfg.grid_origin_x);
    assign w_dy = D_W'(r_pose_y) + D_W'(r_offy) - D_W'(i_cfg.grid_origin_y);

    assign w_sumx = {1'b0, r_mxh} + {17'b0, r_mxl[P_W-1:16]};
    assign w_sumy = {1'b0, r_myh} + {17'b0, r_myl[P_W-1:16]};
    assign w_qx   = r_sx ? -$signed({1'b0, w_sumx[P_W:16]}) : $signed({1'b0, w_sumx[P_W:16]});
    assign w_qy   = r_sy ? -$signed({1'b0, w_sumy[P_W:16]}) : $signed({1'b0, w_sumy[P_W:16]});

    assign w_idx = ({11'b0, r_cy} * {11'b0, i_cfg.grid_width}) + {11'b0, r_cx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ogsh_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_push    = 1'b0;
        o_job.op  = r_op;
        o_job.hit = r_inb;
        o_job.idx = r_inb ? w_idx : '0;
        case (r_state)
            ogsh_pkg::FR_IDLE: begin
                if (w_accept) begin
                    if (i_in_item.operation == ogsh_pkg::OP_READ) begin
                        n_state = ogsh_pkg::FR_BOUND;
                    end else if (w_range_ok) begin
                        n_state = ogsh_pkg::FR_ANGLE;
                    end else begin
                        n_state = ogsh_pkg::FR_ADDR;
                    end
                end
            end
            ogsh_pkg::FR_ANGLE: n_state = ogsh_pkg::FR_ROT;
            ogsh_pkg::FR_ROT: begin
                if (r_step == ogsh_pkg::CORDIC_LAST) begin
                    n_state = ogsh_pkg::FR_PROJ;
                end
            end
            ogsh_pkg::FR_PROJ:  n_state = ogsh_pkg::FR_SUM;
            ogsh_pkg::FR_SUM:   n_state = ogsh_pkg::FR_SCALE;
            ogsh_pkg::FR_SCALE: n_state = ogsh_pkg::FR_CELL;
            ogsh_pkg::FR_CELL:  n_state = ogsh_pkg::FR_BOUND;
            ogsh_pkg::FR_BOUND: n_state = ogsh_pkg::FR_ADDR;
            ogsh_pkg::FR_ADDR: begin
                if (!i_q_status.full) begin
                    o_push  = 1'b1;
                    n_state = ogsh_pkg::FR_IDLE;
                end
            end
            default: n_state = ogsh_pkg::FR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ogsh_pkg::FR_IDLE: begin
                if (w_accept) begin
                    r_op     <= i_in_item.operation;
                    r_range  <= i_in_item.beam_range;
                    r_pose_x <= i_in_item.pose_x;
                    r_pose_y <= i_in_item.pose_y;
                    r_ang    <= i_in_item.pose_heading + i_cfg.first_beam_angle
                              + 16'(i_in_item.beam_index * i_cfg.beam_angle_step);
                    r_gx     <= G_W'(i_in_item.cell_x);
                    r_gy     <= G_W'(i_in_item.cell_y);
                    r_inb    <= 1'b0;
                end
            end
            ogsh_pkg::FR_ANGLE: begin
                r_x    <= ogsh_pkg::CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= {w_fold[16], w_fold, 16'b0};
                r_neg  <= w_fold_neg;
                r_step <= '0;
            end
            ogsh_pkg::FR_ROT: begin
                if (!r_z[CW-1]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_atan;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_atan;
                end
                r_step <= r_step + 5'd1;
            end
            ogsh_pkg::FR_PROJ: begin
                r_offx <= w_px[67:30];
                r_offy <= w_py[67:30];
            end
            ogsh_pkg::FR_SUM: begin
                r_sx <= w_dx[D_W-1];
                r_sy <= w_dy[D_W-1];
                r_mx <= w_dx[D_W-1] ? D_W'(-w_dx) : D_W'(w_dx);
                r_my <= w_dy[D_W-1] ? D_W'(-w_dy) : D_W'(w_dy);
            end
            ogsh_pkg::FR_SCALE: begin
                r_mxh <= r_mx * i_cfg.cells_per_meter[31:16];
                r_mxl <= r_mx * i_cfg.cells_per_meter[15:0];
                r_myh <= r_my * i_cfg.cells_per_meter[31:16];
                r_myl <= r_my * i_cfg.cells_per_meter[15:0];
            end
            ogsh_pkg::FR_CELL: begin
                r_gx <= w_qx;
                r_gy <= w_qy;
            end
            ogsh_pkg::FR_BOUND: begin
                r_inb <= !r_gx[G_W-1] && !r_gy[G_W-1]
                      && (r_gx < $signed(G_W'(i_cfg.grid_width)))
                      && (r_gy < $signed(G_W'(i_cfg.grid_height)));
                r_cx  <= r_gx[10:0];
                r_cy  <= r_gy[10:0];
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/core/ogsh_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogsh_queue
// Two-entry job queue between the sequencer and the cell store.
// ----------------------------------------------------------------------------
module ogsh_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ogsh_pkg::t_job      i_job,
    input  logic                i_pop,
    output ogsh_pkg::t_job      o_job,
    output ogsh_pkg::t_q_status o_status
);

    ogsh_pkg::t_job r_slot [2];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_count;

    assign o_job           = r_slot[r_rd_ptr];
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ rtl/core/ogsh_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogsh_back
// Cell store: clearing pass after reset, read-modify-write of hits, reads,
// and the registered result item.
// ----------------------------------------------------------------------------
module ogsh_back #(
    parameter int unsigned GRID_CELLS = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ogsh_pkg::t_job      i_job,
    input  ogsh_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ogsh_pkg::t_out_item o_out_item
);

    localparam int unsigned AW = $clog2(GRID_CELLS);
    localparam logic [ogsh_pkg::IDX_W-1:0] GRID_LIM = GRID_CELLS[ogsh_pkg::IDX_W-1:0];
    localparam logic [AW-1:0] LAST_ADDR = AW'(GRID_CELLS - 1);

    logic [7:0] r_mem [GRID_CELLS];

    ogsh_pkg::t_back_state r_state, n_state;
    logic [AW-1:0]         r_clr_addr;
    ogsh_pkg::t_job        r_job;
    logic [7:0]            r_rd;
    logic                  r_out_valid;
    ogsh_pkg::t_out_item   r_out;

    logic       w_hit, w_we, w_load;
    logic [AW-1:0] w_wa;
    logic [7:0] w_wd, w_new;

    assign w_hit = r_job.hit && (r_job.idx < GRID_LIM);
    assign w_new = (r_rd > ogsh_pkg::HIT_LIMIT) ? ogsh_pkg::HIT_SAT : r_rd + ogsh_pkg::HIT_STEP;

    assign o_clearing  = (r_state == ogsh_pkg::BK_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ogsh_pkg::BK_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_wa    = r_clr_addr;
        w_wd    = ogsh_pkg::CELL_RESET;
        w_load  = 1'b0;
        case (r_state)
            ogsh_pkg::BK_CLEAR: begin
                w_we = 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ogsh_pkg::BK_IDLE;
                end
            end
            ogsh_pkg::BK_IDLE: begin
                if (!i_q_status.empty && (!r_out_valid || i_out_ready)) begin
                    o_pop   = 1'b1;
                    n_state = ogsh_pkg::BK_RMW;
                end
            end
            ogsh_pkg::BK_RMW: begin
                w_load  = 1'b1;
                w_we    = w_hit && (r_job.op == ogsh_pkg::OP_UPDATE);
                w_wa    = r_job.idx[AW-1:0];
                w_wd    = w_new;
                n_state = ogsh_pkg::BK_IDLE;
            end
            default: n_state = ogsh_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (o_pop) begin
            r_rd  <= r_mem[i_job.idx[AW-1:0]];
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.cell_valid   <= w_hit;
            r_out.cell_value   <= !w_hit ? 8'd0
                                : (r_job.op == ogsh_pkg::OP_READ) ? r_rd : w_new;
            r_out.cell_address <= w_hit ? r_job.idx[15:0] : 16'd0;
        end
    end

endmodule

@@ rtl/core/occupancy_grid_scan_hit_update_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_scan_hit_update_core
// Lidar beam endpoint hit counting into an occupancy grid, with cell reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one item: a
//   beam update (pose, beam index, range) or a read of one cell.
//   Output channel (o_out_valid / i_out_ready / o_out_item) gives exactly one
//   item per input item, in order: the new or read cell value, whether a cell
//   was accessed, and its linear address.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data),
//   to be written by the user only while the block is idle (unchecked).
//   A beam update runs through the front sequencer: angle, the 24 CORDIC
//   iterations, projection, sum, scaling, cell, bounds and address; a read
//   runs only bounds and address, and a rejected range only address. The
//   cell store then takes each job through a registered read and a
//   read-modify-write step that writes back hit updates and loads the result.
//   A new item is accepted only once the job of the last one is queued.
//   After reset the store runs a clearing pass over all GRID_CELLS cells that
//   sets every cell to 127; no item is accepted until it ends.
//   A stalled receiver holds the output register; a two-entry job queue lets
//   the front sequencer finish further items until the queue fills.
// ----------------------------------------------------------------------------
`include "occupancy_grid_scan_hit_update_core_assert.svh"

module occupancy_grid_scan_hit_update_core #(
    parameter int unsigned GRID_CELLS = 65536
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ogsh_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ogsh_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [ogsh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);

    ogsh_pkg::t_cfg      r_cfg;
    ogsh_pkg::t_job      w_push_job, w_head_job;
    ogsh_pkg::t_q_status w_q_status;
    logic                w_push, w_pop, w_clearing;

    // configuration registers, each keeps only its own width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width       <= 11'd256;
            r_cfg.grid_height      <= 11'd256;
            r_cfg.cells_per_meter  <= 32'd655360;
            r_cfg.grid_origin_x    <= '0;
            r_cfg.grid_origin_y    <= '0;
            r_cfg.first_beam_angle <= '0;
            r_cfg.beam_angle_step  <= '0;
            r_cfg.max_valid_range  <= 31'd655360;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ogsh_pkg::CFG_GRID_WIDTH:  r_cfg.grid_width       <= i_cfg_data[10:0];
                ogsh_pkg::CFG_GRID_HEIGHT: r_cfg.grid_height      <= i_cfg_data[10:0];
                ogsh_pkg::CFG_CELLS_PER_M: r_cfg.cells_per_meter  <= i_cfg_data;
                ogsh_pkg::CFG_ORIGIN_X:    r_cfg.grid_origin_x    <= i_cfg_data;
                ogsh_pkg::CFG_ORIGIN_Y:    r_cfg.grid_origin_y    <= i_cfg_data;
                ogsh_pkg::CFG_FIRST_ANGLE: r_cfg.first_beam_angle <= i_cfg_data[15:0];
                ogsh_pkg::CFG_ANGLE_STEP:  r_cfg.beam_angle_step  <= i_cfg_data[15:0];
                ogsh_pkg::CFG_MAX_RANGE:   r_cfg.max_valid_range  <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // front: accept, classify, project the endpoint to a cell
    ogsh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_enable   (!w_clearing),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_push     (w_push),
        .o_job      (w_push_job),
        .i_q_status (w_q_status)
    );

    // decouple the sequencer from the store
    ogsh_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    // back: cell store and result register
    ogsh_back #(
        .GRID_CELLS (GRID_CELLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head_job),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    `OGSH_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, w_clearing, !o_in_ready, "item accepted during clearing pass")
    `OGSH_ASSERT_IMP(a_queue_no_overflow, i_clk, i_rst_n, w_push, !w_q_status.full, "job pushed into full queue")
    `OGSH_ASSERT_IMP(a_miss_is_zero, i_clk, i_rst_n, o_out_valid && !o_out_item.cell_valid, (o_out_item.cell_value == 8'd0) && (o_out_item.cell_address == 16'd0), "miss result not zero")
    `OGSH_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "front ready right after accepting an item")

endmodule

@@ verif/occupancy_grid_scan_hit_update_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_scan_hit_update_core_test
// Self-checking bench for the occupancy grid core. A queue of beam updates
// and cell reads feeds a clocked driver; a clocked monitor compares each
// output item, field by field, with a predicted cell result. Configuration
// changes between phases while the core is idle.
// ----------------------------------------------------------------------------
module occupancy_grid_scan_hit_update_core_test;

    localparam int unsigned STORE_CELLS = 65536;
    localparam int unsigned WATCHDOG_LIMIT = 200000;
    // store clearing pass after reset, plus margin
    localparam int unsigned CLEAR_SLACK = STORE_CELLS + 1000;
    localparam int unsigned DRAIN_CYCLES = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ogsh_pkg::t_in_item in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ogsh_pkg::t_out_item out_item;
    logic cfg_we = 1'b0;
    logic [ogsh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #2 i_clk = ~i_clk;

    occupancy_grid_scan_hit_update_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // Predicted grid contents and register copy
    logic [7:0] grid_cells [STORE_CELLS];
    ogsh_pkg::t_cfg grid_cfg;
    ogsh_pkg::t_in_item beam_queue [$];
    ogsh_pkg::t_out_item cell_results [$];
    int unsigned mismatch_count = 0;
    bit idling_on = 1'b1;
    int unsigned accepted_items = 0;

    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    task automatic beam_sin_cos(input logic [15:0] angle, output longint c,
                                output longint s);
        longint a, x, y, z, xs, ys;
        bit neg;
        a = longint'($signed(angle));
        neg = 1'b0;
        if (a > 16384) begin
            a -= 32768;
            neg = 1'b1;
        end else if (a < -16384) begin
            a += 32768;
            neg = 1'b1;
        end
        x = 652032874;
        y = 0;
        z = a * 65536;
        for (int i = 0; i < 24; i++) begin
            xs = shift_floor(x, i);
            ys = shift_floor(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(ogsh_pkg::atan_step(5'(i)));
            end else begin
                x += ys; y -= xs; z += longint'(ogsh_pkg::atan_step(5'(i)));
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    function automatic longint metres_to_cell(longint d, logic [31:0] cpm);
        longint unsigned m, hi, lo, q;
        m = (d < 0) ? longint'(-d) : longint'(d);
        hi = cpm >> 16;
        lo = cpm & 32'hFFFF;
        q = ((m * hi) + ((m * lo) >> 16)) >> 16;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Apply one item to the predicted grid and return its cell result
    task automatic predict_cell(input ogsh_pkg::t_in_item it,
                                output ogsh_pkg::t_out_item res);
        longint gx, gy, idx, c, s, wx, wy, w, h;
        logic [15:0] ang;
        logic [7:0] v;
        res = '0;
        w = grid_cfg.grid_width;
        h = grid_cfg.grid_height;
        if (it.operation == ogsh_pkg::OP_READ) begin
            gx = it.cell_x;
            gy = it.cell_y;
        end else begin
            if (it.beam_range < ogsh_pkg::MIN_RANGE
                || it.beam_range > grid_cfg.max_valid_range)
                return;
            ang = it.pose_heading + grid_cfg.first_beam_angle
                + 16'(it.beam_index * grid_cfg.beam_angle_step);
            beam_sin_cos(ang, c, s);
            wx = longint'(it.pose_x) + shift_floor(longint'(it.beam_range) * c, 30);
            wy = longint'(it.pose_y) + shift_floor(longint'(it.beam_range) * s, 30);
            gx = metres_to_cell(wx - longint'(grid_cfg.grid_origin_x),
                                grid_cfg.cells_per_meter);
            gy = metres_to_cell(wy - longint'(grid_cfg.grid_origin_y),
                                grid_cfg.cells_per_meter);
        end
        if (gx < 0 || gx >= w || gy < 0 || gy >= h) return;
        idx = gy * w + gx;
        if (idx >= STORE_CELLS) return;
        if (it.operation == ogsh_pkg::OP_READ) begin
            v = grid_cells[idx];
        end else begin
            v = (grid_cells[idx] > ogsh_pkg::HIT_LIMIT) ? ogsh_pkg::HIT_SAT
                : grid_cells[idx] + ogsh_pkg::HIT_STEP;
            grid_cells[idx] = v;
        end
        res.cell_value = v;
        res.cell_valid = 1'b1;
        res.cell_address = 16'(idx);
    endtask

    // Driver: hold valid and payload until accepted, idle in bursts
    int unsigned send_gap = 0;
    always @(posedge i_clk) begin
        ogsh_pkg::t_out_item r;
        if (in_valid && in_ready) begin
            predict_cell(in_item, r);
            cell_results.push_back(r);
            accepted_items++;
        end
        if (!in_valid || in_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (i_rst_n && beam_queue.size() > 0) begin
                in_item <= beam_queue.pop_front();
                in_valid <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 9);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each output item, stall the receiver in bursts
    int unsigned stall_left = 0;
    always @(posedge i_clk) begin
        ogsh_pkg::t_out_item exp_res;
        if (out_valid && out_ready) begin
            if (cell_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected output item %p", out_item);
            end else begin
                exp_res = cell_results.pop_front();
                if (out_item.cell_value !== exp_res.cell_value
                    || out_item.cell_valid !== exp_res.cell_valid
                    || out_item.cell_address !== exp_res.cell_address) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %p, got %p", exp_res, out_item);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 8);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no accepted item on either side
    int unsigned quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG_LIMIT + CLEAR_SLACK) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [ogsh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            ogsh_pkg::CFG_GRID_WIDTH:  grid_cfg.grid_width = val[10:0];
            ogsh_pkg::CFG_GRID_HEIGHT: grid_cfg.grid_height = val[10:0];
            ogsh_pkg::CFG_CELLS_PER_M: grid_cfg.cells_per_meter = val;
            ogsh_pkg::CFG_ORIGIN_X:    grid_cfg.grid_origin_x = val;
            ogsh_pkg::CFG_ORIGIN_Y:    grid_cfg.grid_origin_y = val;
            ogsh_pkg::CFG_FIRST_ANGLE: grid_cfg.first_beam_angle = val[15:0];
            ogsh_pkg::CFG_ANGLE_STEP:  grid_cfg.beam_angle_step = val[15:0];
            default:                   grid_cfg.max_valid_range = val[30:0];
        endcase
    endtask

    // Wait until every item has been sent and every result has come
    task automatic drain_all();
        wait (beam_queue.size() == 0 && !in_valid && cell_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic ogsh_pkg::t_in_item rand_beam();
        ogsh_pkg::t_in_item it;
        it = '0;
        it.operation = ogsh_pkg::OP_UPDATE;
        // poses and ranges mostly land inside a small grid near the origin
        it.pose_x = $signed($urandom_range(0, 32'h00100000)) - 32'sh00080000;
        it.pose_y = $signed($urandom_range(0, 32'h00100000)) - 32'sh00080000;
        it.pose_heading = 16'($urandom);
        it.beam_index = 12'($urandom);
        it.beam_range = 31'($urandom_range(0, 32'h000C0000));
        it.cell_x = 12'($urandom);
        it.cell_y = 12'($urandom);
        if ($urandom_range(0, 15) == 0) begin
            it.pose_x = $urandom;
            it.pose_y = $urandom;
            it.beam_range = 31'($urandom);
        end
        return it;
    endfunction

    function automatic ogsh_pkg::t_in_item rand_read();
        ogsh_pkg::t_in_item it;
        it = rand_beam();
        it.operation = ogsh_pkg::OP_READ;
        it.cell_x = 12'($signed($urandom_range(0, 2048)) - 1024);
        it.cell_y = 12'($signed($urandom_range(0, 2048)) - 1024);
        if ($urandom_range(0, 1) == 0) begin
            it.cell_x = 12'($urandom_range(0, 40));
            it.cell_y = 12'($urandom_range(0, 40));
        end
        return it;
    endfunction

    task automatic queue_random(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            beam_queue.push_back(($urandom_range(0, 2) == 0) ? rand_read() : rand_beam());
    endtask

    initial begin
        ogsh_pkg::t_in_item it;
        grid_cfg.grid_width = 11'd256;
        grid_cfg.grid_height = 11'd256;
        grid_cfg.cells_per_meter = 32'd655360;
        grid_cfg.grid_origin_x = '0;
        grid_cfg.grid_origin_y = '0;
        grid_cfg.first_beam_angle = '0;
        grid_cfg.beam_angle_step = '0;
        grid_cfg.max_valid_range = 31'd655360;
        for (int i = 0; i < STORE_CELLS; i++) grid_cells[i] = ogsh_pkg::CELL_RESET;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reads at corners and outside, short and long ranges,
        // repeated hits to saturate one cell, all four quadrants
        it = '0;
        it.operation = ogsh_pkg::OP_READ;
        it.cell_x = 12'sd0; it.cell_y = 12'sd0; beam_queue.push_back(it);
        it.cell_x = 12'sd255; it.cell_y = 12'sd255; beam_queue.push_back(it);
        it.cell_x = -12'sd1024; it.cell_y = 12'sd1024; beam_queue.push_back(it);
        it.cell_x = 12'sd256; it.cell_y = 12'sd0; beam_queue.push_back(it);
        it = '0;
        it.operation = ogsh_pkg::OP_UPDATE;
        it.pose_x = 32'sh00050000; it.pose_y = 32'sh00050000;
        it.beam_range = 31'd655; beam_queue.push_back(it);
        it.beam_range = 31'd656; beam_queue.push_back(it);
        it.beam_range = 31'd655361; beam_queue.push_back(it);
        it.beam_range = 31'h7FFFFFFF; beam_queue.push_back(it);
        it.beam_range = 31'd65536;
        for (int i = 0; i < 11; i++) beam_queue.push_back(it);
        for (int q = 0; q < 4; q++) begin
            it.pose_heading = 16'(q * 16384 + 8192);
            it.beam_index = 12'hFFF;
            beam_queue.push_back(it);
        end
        it.pose_x = 32'sh7FFFFFFF; it.pose_y = -32'sh80000000;
        it.pose_heading = 16'sh8000; beam_queue.push_back(it);
        it = '0;
        it.operation = ogsh_pkg::OP_READ;
        it.cell_x = 12'sd60; it.cell_y = 12'sd60; beam_queue.push_back(it);
        drain_all();

        // Phases over several register settings, extremes included
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(ogsh_pkg::CFG_GRID_WIDTH, 32'd64);
                    write_reg(ogsh_pkg::CFG_GRID_HEIGHT, 32'd64);
                    write_reg(ogsh_pkg::CFG_CELLS_PER_M, 32'd1310720);
                    write_reg(ogsh_pkg::CFG_ORIGIN_X, -32'sh00080000);
                    write_reg(ogsh_pkg::CFG_ORIGIN_Y, -32'sh00080000);
                    write_reg(ogsh_pkg::CFG_FIRST_ANGLE, 32'h0000C000);
                    write_reg(ogsh_pkg::CFG_ANGLE_STEP, 32'd91);
                    write_reg(ogsh_pkg::CFG_MAX_RANGE, 32'h000A0000);
                end
                1: begin
                    write_reg(ogsh_pkg::CFG_GRID_WIDTH, 32'd1024);
                    write_reg(ogsh_pkg::CFG_GRID_HEIGHT, 32'd1024);
                    write_reg(ogsh_pkg::CFG_CELLS_PER_M, 32'hFFFFFFFF);
                    write_reg(ogsh_pkg::CFG_ANGLE_STEP, 32'h00008000);
                    write_reg(ogsh_pkg::CFG_MAX_RANGE, 32'h7FFFFFFF);
                end
                2: begin
                    write_reg(ogsh_pkg::CFG_GRID_WIDTH, 32'd0);
                    write_reg(ogsh_pkg::CFG_CELLS_PER_M, 32'd1);
                end
                3: begin
                    write_reg(ogsh_pkg::CFG_GRID_WIDTH, 32'd2047);
                    write_reg(ogsh_pkg::CFG_GRID_HEIGHT, 32'd2047);
                    write_reg(ogsh_pkg::CFG_CELLS_PER_M, 32'd0);
                    write_reg(ogsh_pkg::CFG_ORIGIN_X, 32'h7FFFFFFF);
                    write_reg(ogsh_pkg::CFG_ORIGIN_Y, 32'h80000000);
                    write_reg(ogsh_pkg::CFG_FIRST_ANGLE, 32'h00007FFF);
                    write_reg(ogsh_pkg::CFG_ANGLE_STEP, 32'h00007FFF);
                    write_reg(ogsh_pkg::CFG_MAX_RANGE, 32'd0);
                end
                4: begin
                    write_reg(ogsh_pkg::CFG_GRID_WIDTH, 32'd20);
                    write_reg(ogsh_pkg::CFG_GRID_HEIGHT, 32'd20);
                    write_reg(ogsh_pkg::CFG_CELLS_PER_M, 32'd131072);
                    write_reg(ogsh_pkg::CFG_ORIGIN_X, -32'sh000A0000);
                    write_reg(ogsh_pkg::CFG_ORIGIN_Y, -32'sh000A0000);
                    write_reg(ogsh_pkg::CFG_FIRST_ANGLE, 32'h00008000);
                    write_reg(ogsh_pkg::CFG_ANGLE_STEP, 32'hFFFFFFFF);
                    write_reg(ogsh_pkg::CFG_MAX_RANGE, 32'h000F0000);
                end
                5: begin
                    write_reg(ogsh_pkg::CFG_GRID_WIDTH, 32'd1024);
                    write_reg(ogsh_pkg::CFG_GRID_HEIGHT, 32'd70);
                    write_reg(ogsh_pkg::CFG_CELLS_PER_M, 32'd6553600);
                    write_reg(ogsh_pkg::CFG_ORIGIN_X, -32'sh00000000);
                    write_reg(ogsh_pkg::CFG_ORIGIN_Y, -32'sh00000000);
                end
                6: begin
                    write_reg(ogsh_pkg::CFG_GRID_WIDTH, 32'd256);
                    write_reg(ogsh_pkg::CFG_GRID_HEIGHT, 32'd256);
                    write_reg(ogsh_pkg::CFG_CELLS_PER_M, 32'd655360);
                    write_reg(ogsh_pkg::CFG_ORIGIN_X, -32'sh00080000);
                    write_reg(ogsh_pkg::CFG_ORIGIN_Y, -32'sh00080000);
                    write_reg(ogsh_pkg::CFG_FIRST_ANGLE, 32'd0);
                    write_reg(ogsh_pkg::CFG_ANGLE_STEP, 32'd0);
                    write_reg(ogsh_pkg::CFG_MAX_RANGE, 32'h00100000);
                end
                default: idling_on = 1'b0;
            endcase
            queue_random((phase == 2 || phase == 3) ? 40 : 120);
            drain_all();
        end

        if (mismatch_count == 0 && cell_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ogsh_pkg.sv
rtl/core/ogsh_front.sv
rtl/core/ogsh_queue.sv
rtl/core/ogsh_back.sv
rtl/core/occupancy_grid_scan_hit_update_core.sv
verif/occupancy_grid_scan_hit_update_core_test.sv
